@@ hw/rtl/lcg_pkg.sv @@
// shared types and constants for the line color gradient block
// no dependencies; imported by every module of the block
`default_nettype none

package lcg_pkg;

    // default coordinate width of the pixel and end point fields
    localparam int LCG_COORD_WIDTH = 16;

    // number of color channels and the channel saturation value
    localparam int NUM_CH = 3;
    localparam logic [7:0] CH_MAX = 8'hFF;

    // 24-bit color, red in the upper byte
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

endpackage

`default_nettype wire

@@ hw/rtl/lcg_prep.sv @@
// front cells: axis select, span and offset, then the two products per channel
// depends on lcg_pkg
`default_nettype none

module lcg_prep
    import lcg_pkg::*;
#(
    parameter int COORD_WIDTH = LCG_COORD_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // upstream side
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_pixel_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_pixel_y,
    input  wire t_rgb                          i_pixel_rgb,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_y,
    input  wire t_rgb                          i_first_rgb,
    input  wire logic signed [COORD_WIDTH-1:0] i_last_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_last_y,
    input  wire t_rgb                          i_last_rgb,
    input  wire logic                          i_x_major,
    // downstream side
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [COORD_WIDTH+9:0]      o_sd [NUM_CH],
    output logic signed [COORD_WIDTH+9:0]      o_en [NUM_CH],
    output logic [COORD_WIDTH-1:0]             o_dm,
    output logic                               o_bypass,
    output logic [NUM_CH-1:0][7:0]             o_e
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = COORD_WIDTH + 10;

    // stage a: span and offset along the major axis
    logic signed [CW-1:0] w_p, w_a, w_b;
    logic signed [CW:0]   w_d, w_n, w_nn;
    logic [CW:0]          w_dabs;
    logic                 w_bypass;
    logic                 w_a_ready, w_b_ready;

    always_comb begin
        w_p = i_x_major ? i_pixel_x : i_pixel_y;
        w_a = i_x_major ? i_first_x : i_first_y;
        w_b = i_x_major ? i_last_x  : i_last_y;
        w_d = {w_b[CW-1], w_b} - {w_a[CW-1], w_a};
        w_n = {w_p[CW-1], w_p} - {w_a[CW-1], w_a};
        // negative span: flip both span and offset so the span is positive
        w_dabs = w_d[CW] ? (-w_d) : w_d;
        w_nn   = w_d[CW] ? (-w_n) : w_n;
        // end color already reached, or zero span: the end color is the answer
        w_bypass = (i_pixel_rgb == i_last_rgb) || (w_d == '0);
    end

    logic                 r_a_valid;
    logic [CW-1:0]        r_a_dm;
    logic signed [CW:0]   r_a_nn;
    logic [NUM_CH-1:0][7:0] r_a_s, r_a_e;
    logic                 r_a_bypass;

    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_dm     <= w_dabs[CW-1:0];
            r_a_nn     <= w_nn;
            r_a_s      <= i_first_rgb;
            r_a_e      <= i_last_rgb;
            r_a_bypass <= w_bypass;
        end
    end

    // stage b: s*d and (e-s)*n for each channel
    logic signed [PW-1:0] w_sd [NUM_CH];
    logic signed [PW-1:0] w_en [NUM_CH];
    logic [8:0]           w_es [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_es[c] = {1'b0, r_a_e[c]} - {1'b0, r_a_s[c]};
            w_sd[c] = $signed({{(CW+2){1'b0}}, r_a_s[c]}) * $signed({10'b0, r_a_dm});
            w_en[c] = $signed({{(CW+1){w_es[c][8]}}, w_es[c]})
                    * $signed({{9{r_a_nn[CW]}}, r_a_nn});
        end
    end

    logic r_b_valid;

    assign w_b_ready = !r_b_valid || i_ready;
    assign o_valid   = r_b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready && r_a_valid) begin
            for (int c = 0; c < NUM_CH; c++) begin
                o_sd[c] <= w_sd[c];
                o_en[c] <= w_en[c];
            end
            o_dm     <= r_a_dm;
            o_bypass <= r_a_bypass;
            o_e      <= r_a_e;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lcg_norm.sv @@
// numerator cell: sums the products, settles the clamped and bypass cases
// and loads the remainder and quotient preset for the divider cells; uses lcg_pkg
`default_nettype none

module lcg_norm
    import lcg_pkg::*;
#(
    parameter int COORD_WIDTH = LCG_COORD_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [COORD_WIDTH+9:0]  i_sd [NUM_CH],
    input  wire logic signed [COORD_WIDTH+9:0]  i_en [NUM_CH],
    input  wire logic [COORD_WIDTH-1:0]         i_dm,
    input  wire logic                           i_bypass,
    input  wire logic [NUM_CH-1:0][7:0]         i_e,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [COORD_WIDTH+7:0]              o_rem [NUM_CH],
    output logic [NUM_CH-1:0][7:0]              o_q,
    output logic [COORD_WIDTH-1:0]              o_dm
);

    localparam int CW = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + 11;
    localparam int RW = COORD_WIDTH + 8;

    logic signed [NW-1:0] w_num [NUM_CH];
    logic [RW-1:0]        w_rem [NUM_CH];
    logic [NUM_CH-1:0][7:0] w_q;
    logic                 w_neg, w_over;
    logic [CW-1:0]        w_dm;

    // negative numerator clamps to zero, numerator at or past 256 spans to full scale
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_num[c] = {i_sd[c][CW+9], i_sd[c]} + {i_en[c][CW+9], i_en[c]};
            w_neg    = w_num[c][NW-1];
            w_over   = !w_neg && (w_num[c][NW-2:0] >= {2'b00, i_dm, 8'h00});
            w_rem[c] = (i_bypass || w_neg || w_over) ? '0 : w_num[c][RW-1:0];
            if (i_bypass) begin
                w_q[c] = i_e[c];
            end else if (w_over) begin
                w_q[c] = CH_MAX;
            end else begin
                w_q[c] = '0;
            end
        end
        // a unit divisor keeps the divider cells from setting bits on bypass
        w_dm = i_bypass ? {{(CW-1){1'b0}}, 1'b1} : i_dm;
    end

    logic r_valid;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int c = 0; c < NUM_CH; c++) begin
                o_rem[c] <= w_rem[c];
            end
            o_q  <= w_q;
            o_dm <= w_dm;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lcg_div_cell.sv @@
// one restoring division cell: resolves quotient bit BIT for all channels
// depends on lcg_pkg
`default_nettype none

module lcg_div_cell
    import lcg_pkg::*;
#(
    parameter int COORD_WIDTH = LCG_COORD_WIDTH,
    parameter int BIT         = 7
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [COORD_WIDTH+7:0]    i_rem [NUM_CH],
    input  wire logic [NUM_CH-1:0][7:0]    i_q,
    input  wire logic [COORD_WIDTH-1:0]    i_dm,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [COORD_WIDTH+7:0]         o_rem [NUM_CH],
    output logic [NUM_CH-1:0][7:0]         o_q,
    output logic [COORD_WIDTH-1:0]         o_dm
);

    localparam int RW = COORD_WIDTH + 8;

    logic [RW-1:0]          w_dsh;
    logic [RW:0]            w_diff [NUM_CH];
    logic [RW-1:0]          w_rem [NUM_CH];
    logic [NUM_CH-1:0][7:0] w_q;

    // trial subtract of the shifted divisor, keep it when it does not borrow
    always_comb begin
        w_dsh = {8'h00, i_dm} << BIT;
        w_q   = i_q;
        for (int c = 0; c < NUM_CH; c++) begin
            w_diff[c] = {1'b0, i_rem[c]} - {1'b0, w_dsh};
            w_rem[c]  = w_diff[c][RW] ? i_rem[c] : w_diff[c][RW-1:0];
            w_q[c][BIT] = i_q[c][BIT] | !w_diff[c][RW];
        end
    end

    logic r_valid;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int c = 0; c < NUM_CH; c++) begin
                o_rem[c] <= w_rem[c];
            end
            o_q  <= w_q;
            o_dm <= i_dm;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/line_color_gradient.sv @@
// top level of the line color gradient shader: front cells, numerator cell
// and a row of eight division cells; depends on lcg_pkg, lcg_prep, lcg_norm, lcg_div_cell
//
//  channel   direction  handshake                     payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata: pixel, start, end; tuser: x_major
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata: shaded_rgb
//
// one pixel per cycle sustained while the sink keeps ready high; stages: two front stages
// (span, then products), one numerator stage and eight division cells,
// one quotient bit per cell
// reset clears only the valid bit of every stage
// each stage holds while full and its neighbor stalls; ready ripples back,
// so bubbles are filled while a result waits at the output
`default_nettype none

module line_color_gradient
    import lcg_pkg::*;
#(
    parameter int COORD_WIDTH = LCG_COORD_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // pixel_x, pixel_y, pixel_rgb, first_x, first_y, first_rgb,
    // last_x, last_y, last_rgb, zero fill
    input  wire logic [((6*COORD_WIDTH+72+7)/8)*8-1:0] i_s_axis_tdata,
    // x_major
    input  wire logic [0:0]           i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // shaded_rgb (blue, green, red)
    output logic [23:0]               o_m_axis_tdata
);

    localparam int CW = COORD_WIDTH;
    localparam int RW = COORD_WIDTH + 8;
    localparam int NCELL = 8;

    // field unpacking of the input transaction
    logic signed [CW-1:0] w_pixel_x, w_pixel_y, w_first_x, w_first_y, w_last_x, w_last_y;
    t_rgb                 w_pixel_rgb, w_first_rgb, w_last_rgb;

    assign w_pixel_x   = i_s_axis_tdata[CW-1:0];
    assign w_pixel_y   = i_s_axis_tdata[2*CW-1:CW];
    assign w_pixel_rgb = i_s_axis_tdata[2*CW+23:2*CW];
    assign w_first_x   = i_s_axis_tdata[3*CW+23:2*CW+24];
    assign w_first_y   = i_s_axis_tdata[4*CW+23:3*CW+24];
    assign w_first_rgb = i_s_axis_tdata[4*CW+47:4*CW+24];
    assign w_last_x    = i_s_axis_tdata[5*CW+47:4*CW+48];
    assign w_last_y    = i_s_axis_tdata[6*CW+47:5*CW+48];
    assign w_last_rgb  = i_s_axis_tdata[6*CW+71:6*CW+48];

    // front cells
    logic                   w_p_valid, w_p_ready;
    logic signed [CW+9:0]   w_sd [NUM_CH];
    logic signed [CW+9:0]   w_en [NUM_CH];
    logic [CW-1:0]          w_p_dm;
    logic                   w_p_bypass;
    logic [NUM_CH-1:0][7:0] w_p_e;

    lcg_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_pixel_x   (w_pixel_x),
        .i_pixel_y   (w_pixel_y),
        .i_pixel_rgb (w_pixel_rgb),
        .i_first_x   (w_first_x),
        .i_first_y   (w_first_y),
        .i_first_rgb (w_first_rgb),
        .i_last_x    (w_last_x),
        .i_last_y    (w_last_y),
        .i_last_rgb  (w_last_rgb),
        .i_x_major   (i_s_axis_tuser[0]),
        .o_valid     (w_p_valid),
        .i_ready     (w_p_ready),
        .o_sd        (w_sd),
        .o_en        (w_en),
        .o_dm        (w_p_dm),
        .o_bypass    (w_p_bypass),
        .o_e         (w_p_e)
    );

    // chain links: index 0 is the numerator cell output, NCELL the last cell
    logic [NCELL:0]         w_valid, w_ready;
    logic [RW-1:0]          w_rem [NCELL+1][NUM_CH];
    logic [NUM_CH-1:0][7:0] w_q   [NCELL+1];
    logic [CW-1:0]          w_dm  [NCELL+1];

    lcg_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_p_valid),
        .o_ready  (w_p_ready),
        .i_sd     (w_sd),
        .i_en     (w_en),
        .i_dm     (w_p_dm),
        .i_bypass (w_p_bypass),
        .i_e      (w_p_e),
        .o_valid  (w_valid[0]),
        .i_ready  (w_ready[0]),
        .o_rem    (w_rem[0]),
        .o_q      (w_q[0]),
        .o_dm     (w_dm[0])
    );

    // division cells, most significant quotient bit first
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        lcg_div_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .BIT         (NCELL - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_rem   (w_rem[k]),
            .i_q     (w_q[k]),
            .i_dm    (w_dm[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_q     (w_q[k+1]),
            .o_dm    (w_dm[k+1])
        );
    end

    // the last cell's register is the output transaction
    assign w_ready[NCELL]  = i_m_axis_tready;
    assign o_m_axis_tvalid = w_valid[NCELL];
    assign o_m_axis_tdata  = w_q[NCELL];

endmodule

`default_nettype wire

@@ hw/rtl/lcg_checker.sv @@
// port-level assertions for line_color_gradient, attached by the bind below
// depends on lcg_pkg and line_color_gradient
`default_nettype none

module lcg_checker
    import lcg_pkg::*;
#(
    parameter int COORD_WIDTH = LCG_COORD_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        o_s_axis_tready,
    input  wire logic [((6*COORD_WIDTH+72+7)/8)*8-1:0] i_s_axis_tdata,
    input  wire logic [0:0]  i_s_axis_tuser,
    input  wire logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [23:0] o_m_axis_tdata
);

    // a waiting input transaction stays offered with its fields unchanged
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready |=> i_s_axis_tvalid
            && $stable(i_s_axis_tdata) && $stable(i_s_axis_tuser))
        else $error("input transaction changed while stalled");

    // a result waiting for the sink stays offered
    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    // and its color does not change under the stall
    a_out_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output color changed while stalled");

    // reset empties the whole chain
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered right after reset");

    // with the last cell empty, every cell can move, so the input is open
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked while the output is empty");

endmodule

bind line_color_gradient lcg_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lcg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

@@ verif/line_color_gradient_checker.sv @@
// checker for the line color gradient shader: watches both streams, predicts
// each pixel's shaded color and compares it with the output; depends on lcg_pkg
module line_color_gradient_checker
    import lcg_pkg::*;
#(
    parameter int COORD_WIDTH = LCG_COORD_WIDTH,
    parameter int TDATA_WIDTH = ((6*COORD_WIDTH+72+7)/8)*8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    // pixel_x, pixel_y, pixel_rgb, first_x, first_y, first_rgb,
    // last_x, last_y, last_rgb, zero fill
    input  wire logic [TDATA_WIDTH-1:0] i_s_tdata,
    // x_major
    input  wire logic [0:0]             i_s_tuser,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    // shaded_rgb (blue, green, red)
    input  wire logic [23:0]            i_m_tdata,
    output int                          o_pending,
    output int                          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // bit offsets of the fields inside tdata
    localparam int PIX_X_LSB   = 0;
    localparam int PIX_Y_LSB   = COORD_WIDTH;
    localparam int PIX_RGB_LSB = 2*COORD_WIDTH;
    localparam int FST_X_LSB   = 2*COORD_WIDTH + 24;
    localparam int FST_Y_LSB   = 3*COORD_WIDTH + 24;
    localparam int FST_RGB_LSB = 4*COORD_WIDTH + 24;
    localparam int LST_X_LSB   = 4*COORD_WIDTH + 48;
    localparam int LST_Y_LSB   = 5*COORD_WIDTH + 48;
    localparam int LST_RGB_LSB = 6*COORD_WIDTH + 48;

    logic [23:0] expected_colors[$];
    int          mismatches = 0;

    // sign-extended coordinate at a given offset
    function automatic longint coord_at(input logic [TDATA_WIDTH-1:0] data, input int lsb);
        logic signed [COORD_WIDTH-1:0] c;
        c = data[lsb +: COORD_WIDTH];
        return longint'(c);
    endfunction

    // floor((s*(d-n) + e*n) / d), saturated to one byte
    function automatic logic [7:0] blend_channel(input logic [7:0] s, input logic [7:0] e,
                                                 input longint n, input longint d);
        longint num;
        longint den;
        longint q;
        num = longint'(s) * (d - n) + longint'(e) * n;
        den = d;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        q = num / den;
        // division truncates toward zero, so step down for negative remainders
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        if (q < 0) begin
            q = 0;
        end
        if (q > longint'(CH_MAX)) begin
            q = longint'(CH_MAX);
        end
        return q[7:0];
    endfunction

    function automatic logic [23:0] shade_pixel(input logic [TDATA_WIDTH-1:0] data,
                                                input logic x_major);
        t_rgb   pix;
        t_rgb   c0;
        t_rgb   c1;
        t_rgb   shade;
        longint p;
        longint a;
        longint b;
        longint n;
        longint d;
        pix = data[PIX_RGB_LSB +: 24];
        c0  = data[FST_RGB_LSB +: 24];
        c1  = data[LST_RGB_LSB +: 24];
        // pixel already at the end color passes through
        if (pix == c1) begin
            return pix;
        end
        if (x_major) begin
            p = coord_at(data, PIX_X_LSB);
            a = coord_at(data, FST_X_LSB);
            b = coord_at(data, LST_X_LSB);
        end else begin
            p = coord_at(data, PIX_Y_LSB);
            a = coord_at(data, FST_Y_LSB);
            b = coord_at(data, LST_Y_LSB);
        end
        d = b - a;
        // no span on the major axis means full fraction, the end color
        if (d == 0) begin
            return c1;
        end
        n = p - a;
        shade.r = blend_channel(c0.r, c1.r, n, d);
        shade.g = blend_channel(c0.g, c1.g, n, d);
        shade.b = blend_channel(c0.b, c1.b, n, d);
        return shade;
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_colors.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_colors.push_back(shade_pixel(i_s_tdata, i_s_tuser[0]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_colors.size() == 0) begin
                    $error("shaded_rgb: no transaction expected, got %06h", i_m_tdata);
                    mismatches = mismatches + 1;
                end else begin
                    if (i_m_tdata !== expected_colors[0]) begin
                        $error("shaded_rgb: expected %06h, actual %06h",
                               expected_colors[0], i_m_tdata);
                        mismatches = mismatches + 1;
                    end
                    void'(expected_colors.pop_front());
                end
            end
        end
        o_pending    <= expected_colors.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ verif/line_color_gradient_tb.sv @@
// testbench top for the line color gradient shader: clock, reset, pixel stimulus
// and output back-pressure; depends on lcg_pkg, line_color_gradient, the checker
module line_color_gradient_tb
    import lcg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW      = LCG_COORD_WIDTH;
    localparam int TDATA_W = ((6*CW+72+7)/8)*8;
    localparam int NUM_RANDOM = 1700;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_TRICKLE} t_rx_mode;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic [0:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;
    int                 pending;
    int                 fail_count;

    int       burst_left = 1;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;

    always #5 clk = ~clk;

    line_color_gradient uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    line_color_gradient_checker shade_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // receiver back-pressure: one of four patterns, chosen anew at random whenever its run counter expires
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
            RX_EVERY4:  m_tready <= (rx_left[1:0] == 2'd0);
            default:    m_tready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    function automatic logic [TDATA_W-1:0] pack_pixel(
        input int px, input int py, input logic [23:0] prgb,
        input int fx, input int fy, input logic [23:0] frgb,
        input int lx, input int ly, input logic [23:0] lrgb);
        return TDATA_W'({lrgb, CW'(ly), CW'(lx), frgb, CW'(fy), CW'(fx),
                         prgb, CW'(py), CW'(px)});
    endfunction

    // one pixel transaction; bursts of random length with random gaps between
    task automatic send_pixel(input logic [TDATA_W-1:0] data, input logic x_major);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= x_major;
        do @(posedge clk); while (!s_tready);
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0) begin
                gap = $urandom_range(10, 30);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
    endtask

    function automatic int wide_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // random color, often with every channel at an extreme
    function automatic logic [23:0] rand_color();
        if ($urandom_range(0, 3) == 0) begin
            return {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
                    {8{1'($urandom_range(0, 1))}}};
        end
        return 24'($urandom);
    endfunction

    task automatic send_random_pixel();
        int          kind;
        int          base;
        int          fx;
        int          fy;
        int          lx;
        int          ly;
        int          px;
        int          py;
        int          dx;
        int          dy;
        int          k;
        int          m;
        logic [23:0] prgb;
        logic [23:0] frgb;
        logic [23:0] lrgb;
        logic        xm;
        kind = $urandom_range(0, 99);
        // end points mostly close together, sometimes anywhere
        if ($urandom_range(0, 3) == 0) begin
            fx = wide_coord();
            fy = wide_coord();
            lx = wide_coord();
            ly = wide_coord();
        end else begin
            base = $urandom_range(0, 64000) - 32000;
            fx = base + $urandom_range(0, 1400) - 700;
            lx = base + $urandom_range(0, 1400) - 700;
            base = $urandom_range(0, 64000) - 32000;
            fy = base + $urandom_range(0, 1400) - 700;
            ly = base + $urandom_range(0, 1400) - 700;
        end
        frgb = rand_color();
        lrgb = rand_color();
        prgb = ($urandom_range(0, 15) == 0) ? frgb : rand_color();
        dx = lx - fx;
        dy = ly - fy;
        xm = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy));
        if ($urandom_range(0, 9) == 0) begin
            xm = !xm;
        end
        // pixel on the segment
        m  = $urandom_range(1, 64);
        k  = $urandom_range(0, m);
        px = fx + dx * k / m;
        py = fy + dy * k / m;
        if (kind >= 65 && kind < 80) begin
            // pixel at a random place, usually off the segment
            px = wide_coord();
            py = wide_coord();
        end else if (kind >= 80 && kind < 88) begin
            prgb = lrgb;
        end else if (kind >= 88 && kind < 92) begin
            if (xm) begin
                lx = fx;
            end else begin
                ly = fy;
            end
        end else if (kind >= 92) begin
            // noise on every coordinate, the pixel color and the axis select
            px   = wide_coord();
            py   = wide_coord();
            fx   = wide_coord();
            fy   = wide_coord();
            lx   = wide_coord();
            ly   = wide_coord();
            prgb = 24'($urandom);
            xm   = 1'($urandom_range(0, 1));
        end
        send_pixel(pack_pixel(px, py, prgb, fx, fy, frgb, lx, ly, lrgb), xm);
    endtask

    // stimulus and verdict
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pixel already at the end color: all fields zero, all ones, and a general case
        send_pixel(pack_pixel(0, 0, 24'h000000, 0, 0, 24'h000000, 0, 0, 24'h000000), 1'b0);
        send_pixel(pack_pixel(-1, -1, 24'hFFFFFF, -1, -1, 24'hFFFFFF, -1, -1, 24'hFFFFFF), 1'b1);
        send_pixel(pack_pixel(-1, -1, 24'hFFFFFF, -1, -1, 24'hFFFFFF, -1, -1, 24'hFFFFFF), 1'b0);
        send_pixel(pack_pixel(7, 3, 24'h123456, 0, 0, 24'hABCDEF, 20, 1, 24'h123456), 1'b1);
        // no span on the major axis
        send_pixel(pack_pixel(5, 9, 24'h102030, 4, 0, 24'hFF0000, 4, 40, 24'h00FF00), 1'b1);
        send_pixel(pack_pixel(9, 5, 24'h102030, 0, 4, 24'hFF0000, 40, 4, 24'h0000FF), 1'b0);
        // a midpoint along x, a point a third of the way along y
        send_pixel(pack_pixel(5, 0, 24'hFF0000, 0, 0, 24'h000000, 10, 0, 24'hFFFFFF), 1'b1);
        send_pixel(pack_pixel(0, 1, 24'h000000, 0, 0, 24'h204060, 0, 3, 24'h80A0C0), 1'b0);
        // negative span
        send_pixel(pack_pixel(3, 0, 24'h000000, 10, 0, 24'h00FF80, 0, 0, 24'hFF0040), 1'b1);
        send_pixel(pack_pixel(0, -7, 24'h000000, 0, 0, 24'h0A0B0C, 0, -3, 24'hF0E0D0), 1'b0);
        // pixel beyond the end and before the start, both clamps
        send_pixel(pack_pixel(20, 0, 24'h000000, 0, 0, 24'hFF00FF, 10, 0, 24'h00FF00), 1'b1);
        send_pixel(pack_pixel(-1, 0, 24'h000000, 0, 0, 24'h6400FF, 3, 0, 24'hC8FF01), 1'b1);
        send_pixel(pack_pixel(0, -1, 24'h000000, 0, 0, 24'h01FF00, 0, 2, 24'hFF00FF), 1'b0);
        // coordinate extremes
        send_pixel(pack_pixel(32767, 0, 24'h000000, -32768, 0, 24'h00FF00, 32767, 0,
                              24'hFF00FF), 1'b1);
        send_pixel(pack_pixel(0, 0, 24'h000000, -32768, 0, 24'h00FF00, 32767, 0,
                              24'hFF00FF), 1'b1);
        send_pixel(pack_pixel(0, -32768, 24'h000000, 0, 32767, 24'h804020, 0, -32768,
                              24'h10F0FF), 1'b0);
        send_pixel(pack_pixel(0, 1, 24'h000000, 0, 32767, 24'hFFFFFF, 0, -32768,
                              24'h000000), 1'b0);
        send_pixel(pack_pixel(-32768, 0, 24'h000000, 0, 0, 24'h00FF7F, 1, 0, 24'hFF0080), 1'b1);
        send_pixel(pack_pixel(32767, 0, 24'h000000, 0, 0, 24'h00FF7F, 1, 0, 24'hFF0080), 1'b1);
        // pixel at the start color
        send_pixel(pack_pixel(2, 2, 24'h3C5A78, 0, 0, 24'h3C5A78, 8, 8, 24'hC3A587), 1'b1);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            send_random_pixel();
        end
        s_tvalid <= 1'b0;

        // drain, then wait on so that any stray result is still seen
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hard stop if the streams hang
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/lcg_pkg.sv
hw/rtl/lcg_prep.sv
hw/rtl/lcg_norm.sv
hw/rtl/lcg_div_cell.sv
hw/rtl/line_color_gradient.sv
hw/rtl/lcg_checker.sv
verif/line_color_gradient_checker.sv
verif/line_color_gradient_tb.sv
